[sv/fcra_pkg.sv]
package fcra_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 8;
  localparam logic [15:0] LANE_BIAS = 16'h1357;
  localparam logic [31:0] SEL_A_MASK = 32'h0040_0040;

  localparam logic [31:0] SUBKEY [4] = '{
    32'h529a_bfde, 32'hb76c_28af, 32'he801_3fa7, 32'hf6c4_f62b
  };

  localparam logic [3:0] PERM_A [16] = '{
    4'd8, 4'd6, 4'd10, 4'd4, 4'd12, 4'd2, 4'd14, 4'd0,
    4'd7, 4'd9, 4'd5, 4'd11, 4'd3, 4'd13, 4'd1, 4'd15
  };
  localparam logic [3:0] PERM_B [16] = '{
    4'd7, 4'd14, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd0,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd1, 4'd15
  };
  localparam logic [1:0] BYTES_A [4] = '{2'd0, 2'd3, 2'd1, 2'd2};
  localparam logic [1:0] BYTES_B [4] = '{2'd1, 2'd0, 2'd2, 2'd3};

  typedef struct packed {
    logic load;
    logic key_rnd;
    logic data_rnd;
    logic last;
  } cmd_t;

  function automatic logic [31:0] lane_add(input logic [31:0] x, input logic [31:0] y);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = x[31:16] + y[31:16];
    lo = x[15:0] + y[15:0];
    return {hi, lo};
  endfunction

  function automatic logic [31:0] bit_perm(input logic [31:0] x, input logic use_b);
    logic [31:0] o;
    logic [3:0] s;
    o = '0;
    for (int d = 0; d < 16; d++) begin
      s = use_b ? PERM_B[d] : PERM_A[d];
      o[d] = x[s];
      o[d+16] = x[{1'b1, s}];
    end
    return o;
  endfunction

  function automatic logic [31:0] byte_perm(input logic [31:0] x, input logic use_b);
    logic [31:0] o;
    logic [1:0] s;
    o = '0;
    for (int d = 0; d < 4; d++) begin
      s = use_b ? BYTES_B[d] : BYTES_A[d];
      o[8*d +: 8] = x[8*s +: 8];
    end
    return o;
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [31:0] k);
    logic [31:0] b;
    logic [31:0] kr;
    logic [31:0] kr2;
    logic [31:0] mask;
    logic [31:0] x;
    b = ~lane_add(r, k);
    kr = {k[0], k[31:1]};
    kr2 = {kr[0], kr[31:1]};
    mask = ((^(b & kr)) ? SEL_A_MASK : 32'h0) | ((^(b & kr2)) ? ~SEL_A_MASK : 32'h0);
    x = b ^ (mask & ~kr);
    x = byte_perm(bit_perm(x, 1'b0), 1'b0);
    x = x ^ {x[30:0], x[31]} ^ {x[24:0], x[31:25]};
    x = bit_perm(byte_perm(x, 1'b1), 1'b1);
    x = lane_add(x, lane_add(k, {LANE_BIAS, LANE_BIAS}));
    return {x[30:0], x[31]};
  endfunction

endpackage

[sv/fcra_ctrl.sv]
module fcra_ctrl #(
  parameter int unsigned ROUND_COUNT = fcra_pkg::ROUND_COUNT_DEF,
  localparam int unsigned IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fcra_pkg::cmd_t     cmd_o,
  output logic [IDX_W-1:0]   cnt_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUND_COUNT - 1);

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             at_last;

  assign at_last = (cnt_q == LAST_IDX);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_KEY;
          cnt_d = '0;
        end
      end
      ST_KEY: begin
        cmd_o.key_rnd = 1'b1;
        cmd_o.last = at_last;
        if (at_last) begin
          cnt_d = '0;
          state_d = ST_DATA;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DATA: begin
        cmd_o.data_rnd = 1'b1;
        cmd_o.last = at_last;
        if (at_last) begin
          cnt_d = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign cnt_o = cnt_q;

endmodule

[sv/fcra_dp.sv]
module fcra_dp #(
  parameter int unsigned ROUND_COUNT = fcra_pkg::ROUND_COUNT_DEF,
  localparam int unsigned IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcra_pkg::cmd_t     cmd_i,
  input  logic [IDX_W-1:0]   cnt_i,
  input  logic [63:0]        auth_key_i,
  input  logic [63:0]        challenge_i,
  output logic [63:0]        response_o
);

  logic [63:0] blk_q, blk_d;
  logic [63:0] chal_q;
  logic [63:0] resp_q;
  logic [31:0] rk_q [ROUND_COUNT];
  logic [31:0] key;
  logic [31:0] nlo;

  assign key = cmd_i.key_rnd ? fcra_pkg::SUBKEY[2'(cnt_i)] : rk_q[cnt_i];
  assign nlo = blk_q[63:32] ^ fcra_pkg::round_fn(blk_q[31:0], key);

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.load) begin
      blk_d = auth_key_i;
    end else if (cmd_i.key_rnd && cmd_i.last) begin
      blk_d = chal_q;
    end else if (cmd_i.key_rnd || cmd_i.data_rnd) begin
      blk_d = {blk_q[31:0], nlo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= '0;
    end else begin
      blk_q <= blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chal_q <= challenge_i;
    end
    if (cmd_i.key_rnd) begin
      rk_q[cnt_i] <= nlo;
    end
    if (cmd_i.data_rnd && cmd_i.last) begin
      resp_q <= {nlo, blk_q[31:0]};
    end
  end

  assign response_o = resp_q;

endmodule

[sv/feistel_challenge_response_auth.sv]
// all key schedule rounds, then all challenge rounds, one per cycle through the shared round function
// a new challenge is taken only after the previous response beat
// async active-low reset clears the controller, the work block and auth_key to zero
module feistel_challenge_response_auth #(
  parameter int unsigned ROUND_COUNT = fcra_pkg::ROUND_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        auth_key_we_i,
  input  logic [63:0] auth_key_i,
  input  logic        challenge_valid_i,
  output logic        challenge_stall_o,
  input  logic [63:0] challenge_i,
  output logic        response_valid_o,
  input  logic        response_stall_i,
  output logic [63:0] response_o
);

  localparam int unsigned IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  logic [63:0]      auth_key_q;
  fcra_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auth_key_q <= '0;
    end else if (auth_key_we_i) begin
      auth_key_q <= auth_key_i;
    end
  end

  fcra_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (challenge_valid_i),
    .in_stall_o  (challenge_stall_o),
    .out_valid_o (response_valid_o),
    .out_stall_i (response_stall_i),
    .cmd_o       (cmd),
    .cnt_o       (cnt)
  );

  fcra_dp #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cnt_i       (cnt),
    .auth_key_i  (auth_key_q),
    .challenge_i (challenge_i),
    .response_o  (response_o)
  );

endmodule

[sim/tb_feistel_challenge_response_auth.sv]
`timescale 1ns / 1ps

module tb_feistel_challenge_response_auth;

  localparam int ROUNDS = 8;
  localparam int SETTLE_CYCLES = 2 * ROUNDS + 24;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_LIMIT = 10;

  localparam logic [127:0] SCHEDULE_KEYS = 128'hf6c4f62b_e8013fa7_b76c28af_529abfde;
  localparam logic [63:0] BIT_ORDER_A = 64'hF1D3B597_0E2C4A68;
  localparam logic [63:0] BIT_ORDER_B = 64'hF1DCBA98_065432E7;
  localparam logic [7:0] BYTE_ORDER_A = 8'h9C;
  localparam logic [7:0] BYTE_ORDER_B = 8'hE1;
  localparam logic [31:0] PARITY_A_BITS = 32'h0040_0040;
  localparam logic [31:0] LANE_OFFSET = 32'h1357_1357;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        auth_key_we_i = 1'b0;
  logic [63:0] auth_key_i = '0;
  logic        challenge_valid_i = 1'b0;
  logic        challenge_stall_o;
  logic [63:0] challenge_i = '0;
  logic        response_valid_o;
  logic        response_stall_i = 1'b0;
  logic [63:0] response_o;

  logic [63:0] expected_responses [$];
  logic [63:0] current_key = '0;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          hold_request = 0;
  logic        no_idle = 1'b0;

  feistel_challenge_response_auth dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .auth_key_we_i     (auth_key_we_i),
    .auth_key_i        (auth_key_i),
    .challenge_valid_i (challenge_valid_i),
    .challenge_stall_o (challenge_stall_o),
    .challenge_i       (challenge_i),
    .response_valid_o  (response_valid_o),
    .response_stall_i  (response_stall_i),
    .response_o        (response_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] lane_sum(input logic [31:0] a, input logic [31:0] b);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = a[31:16] + b[31:16];
    lo = a[15:0] + b[15:0];
    return {hi, lo};
  endfunction

  function automatic logic [31:0] shuffle_bits(input logic [31:0] x, input logic [63:0] order);
    logic [31:0] o;
    logic [4:0] s;
    o = '0;
    for (int d = 0; d < 16; d++) begin
      s = {1'b0, order[4*d +: 4]};
      o[d] = x[s];
      o[d+16] = x[s+16];
    end
    return o;
  endfunction

  function automatic logic [31:0] shuffle_bytes(input logic [31:0] x, input logic [7:0] order);
    logic [31:0] o;
    logic [1:0] s;
    o = '0;
    for (int d = 0; d < 4; d++) begin
      s = order[2*d +: 2];
      o[8*d +: 8] = x[8*s +: 8];
    end
    return o;
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] half, input logic [31:0] k);
    logic [31:0] b;
    logic [31:0] k_r1;
    logic [31:0] k_r2;
    logic [31:0] mask;
    logic [31:0] x;
    b = ~lane_sum(half, k);
    k_r1 = {k[0], k[31:1]};
    k_r2 = {k_r1[0], k_r1[31:1]};
    mask = '0;
    if (^(b & k_r1)) mask = mask | PARITY_A_BITS;
    if (^(b & k_r2)) mask = mask | ~PARITY_A_BITS;
    x = b ^ (mask & ~k_r1);
    x = shuffle_bytes(shuffle_bits(x, BIT_ORDER_A), BYTE_ORDER_A);
    x = x ^ {x[30:0], x[31]} ^ {x[24:0], x[31:25]};
    x = shuffle_bits(shuffle_bytes(x, BYTE_ORDER_B), BIT_ORDER_B);
    x = lane_sum(x, lane_sum(k, LANE_OFFSET));
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [63:0] feistel_pass(input logic [63:0] blk, input logic [31:0] k);
    return {blk[31:0], blk[63:32] ^ scramble(blk[31:0], k)};
  endfunction

  function automatic logic [63:0] auth_response(input logic [63:0] key, input logic [63:0] chal);
    logic [31:0] round_keys [ROUNDS];
    logic [63:0] blk;
    blk = key;
    for (int i = 0; i < ROUNDS; i++) begin
      blk = feistel_pass(blk, SCHEDULE_KEYS[32*(i%4) +: 32]);
      round_keys[i] = blk[31:0];
    end
    blk = chal;
    for (int i = 0; i < ROUNDS; i++) begin
      blk = feistel_pass(blk, round_keys[i]);
    end
    return {blk[31:0], blk[63:32]};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0: begin
        return 64'd1 << $urandom_range(0, 63);
      end
      1: begin
        return ~(64'd1 << $urandom_range(0, 63));
      end
      2: begin
        return {$urandom, $urandom} & {$urandom, $urandom};
      end
      3: begin
        return {$urandom, $urandom} | {$urandom, $urandom};
      end
      default: begin
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  task automatic send_challenge(input logic [63:0] value);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      challenge_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    challenge_valid_i <= 1'b1;
    challenge_i <= value;
    do @(posedge clk_i); while (challenge_stall_o);
    expected_responses.push_back(auth_response(current_key, value));
  endtask

  task automatic drain_responses();
    challenge_valid_i <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] value);
    drain_responses();
    auth_key_we_i <= 1'b1;
    auth_key_i <= value;
    @(posedge clk_i);
    auth_key_we_i <= 1'b0;
    current_key = value;
  endtask

  // key left at its reset value of zero
  task automatic test_reset_key();
    send_challenge(64'h0);
    send_challenge(64'hFFFF_FFFF_FFFF_FFFF);
    send_challenge(64'h1);
    send_challenge(64'h8000_0000_0000_0000);
    send_challenge(64'hA5A5_5A5A_0F0F_F0F0);
  endtask

  task automatic test_key_extremes();
    logic [63:0] keys [5];
    keys = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h1,
             64'hFFFF_0000_FFFF_0000, 64'h0};
    foreach (keys[i]) begin
      load_key(keys[i]);
      send_challenge(64'hFFFF_FFFF_FFFF_FFFF);
      send_challenge(64'h0);
      send_challenge(64'h5555_5555_AAAA_AAAA);
    end
  endtask

  task automatic test_random_keys();
    for (int p = 0; p < 5; p++) begin
      load_key(random_word());
      repeat (250) send_challenge(random_word());
    end
  endtask

  task automatic test_back_to_back();
    load_key(random_word());
    no_idle = 1'b1;
    repeat (150) send_challenge(random_word());
    no_idle = 1'b0;
  endtask

  task automatic test_response_hold_off();
    load_key(random_word());
    hold_request = HOLD_OFF_CYCLES;
    repeat (12) send_challenge(random_word());
  endtask

  initial begin : response_pacing
    logic stall_now;
    int run_left;
    stall_now = 1'b0;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        if (hold_request > 0) begin
          stall_now = 1'b1;
          run_left = hold_request;
          hold_request = 0;
        end else if (no_idle) begin
          stall_now = 1'b0;
          run_left = 1;
        end else begin
          stall_now = ($urandom_range(0, 2) == 0);
          run_left = stall_now ? pick_gap() + 1 : $urandom_range(1, 24);
        end
      end
      run_left--;
      response_stall_i <= stall_now;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((challenge_valid_i && !challenge_stall_o) || (response_valid_o && !response_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (response_valid_o && !response_stall_i) begin
        if (expected_responses.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("unexpected response beat: actual %h", response_o);
          error_count++;
        end else begin
          if (response_o !== expected_responses[0]) begin
            if (error_count < REPORT_LIMIT)
              $display("response mismatch: expected %h actual %h",
                       expected_responses[0], response_o);
            error_count++;
          end
          void'(expected_responses.pop_front());
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_key_extremes();
    test_random_keys();
    test_back_to_back();
    test_response_hold_off();
    drain_responses();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
sv/fcra_pkg.sv
sv/fcra_ctrl.sv
sv/fcra_dp.sv
sv/feistel_challenge_response_auth.sv
sim/tb_feistel_challenge_response_auth.sv
